// ===== rtl/sfs_pkg.sv =====
// ----------------------------------------------------------------------------
// sfs_pkg: shared types and constants of the sprite frame sequencer
// Opcodes, play modes, register indexes, datapath widths and the request and
// response bundles of the shared divider.
// ----------------------------------------------------------------------------
`default_nettype none

package sfs_pkg;

  // command opcodes
  localparam logic [2:0] OP_TICK  = 3'd0;
  localparam logic [2:0] OP_PLAY  = 3'd1;
  localparam logic [2:0] OP_PAUSE = 3'd2;
  localparam logic [2:0] OP_STOP  = 3'd3;
  localparam logic [2:0] OP_SETF  = 3'd4;
  localparam logic [2:0] OP_WRITE = 3'd5;

  // configuration register indexes
  localparam logic [2:0] REG_ORIGIN_X = 3'd0;
  localparam logic [2:0] REG_ORIGIN_Y = 3'd1;
  localparam logic [2:0] REG_STEP_X   = 3'd2;
  localparam logic [2:0] REG_STEP_Y   = 3'd3;
  localparam logic [2:0] REG_TPR      = 3'd4;
  localparam logic [2:0] REG_FCOUNT   = 3'd5;
  localparam logic [2:0] REG_LOOP     = 3'd6;

  typedef enum logic [1:0] {
    MODE_PLAYING = 2'd0,
    MODE_PAUSED  = 2'd1,
    MODE_STOPPED = 2'd2
  } mode_t;

  // elapsed time, period sum (up to 127 durations) and frame counter widths
  localparam int ELAPSED_W = 33;
  localparam int PERIOD_W  = 39;
  localparam int CNT_W     = 7;

  typedef struct packed {
    logic                 start;
    logic [ELAPSED_W-1:0] dividend;
    logic [PERIOD_W-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic                 done;
    logic [ELAPSED_W-1:0] quotient;
    logic [PERIOD_W-1:0]  remainder;
  } div_rsp_t;

endpackage

`default_nettype wire

// ===== rtl/sfs_tables.sv =====
// ----------------------------------------------------------------------------
// sfs_tables: frame duration and tile index memories
// One write port shared by both tables, one registered read port returning
// the duration and tile of the same entry.
// ----------------------------------------------------------------------------
`default_nettype none

module sfs_tables #(
  parameter int DEPTH = 64,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] wr_addr,
  input  wire logic [31:0]   wr_dur,
  input  wire logic [15:0]   wr_tile,
  input  wire logic [AW-1:0] rd_addr,
  output logic      [31:0]   rd_dur,
  output logic      [15:0]   rd_tile
);

  logic [31:0] dur_mem  [DEPTH];
  logic [15:0] tile_mem [DEPTH];

  // write both tables together
  always_ff @(posedge clk) begin
    if (we) begin
      dur_mem[wr_addr]  <= wr_dur;
      tile_mem[wr_addr] <= wr_tile;
    end
  end

  // registered read
  always_ff @(posedge clk) begin
    rd_dur  <= dur_mem[rd_addr];
    rd_tile <= tile_mem[rd_addr];
  end

endmodule

`default_nettype wire

// ===== rtl/sfs_divider.sv =====
// ----------------------------------------------------------------------------
// sfs_divider: shared restoring divider
// One quotient bit per cycle; serves the period and duration reductions, the
// set-frame modulo and the tile column/row split.
// ----------------------------------------------------------------------------
`default_nettype none

module sfs_divider
  import sfs_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire div_req_t req,
  output div_rsp_t      rsp
);

  localparam int ITER = ELAPSED_W;
  localparam int IW   = $clog2(ITER + 1);

  logic                 running;
  logic                 done;
  logic [IW-1:0]        count;
  logic [ELAPSED_W-1:0] quo;
  logic [PERIOD_W-1:0]  rem;
  logic [PERIOD_W-1:0]  dsr;

  logic [PERIOD_W:0]    shifted;
  logic [PERIOD_W:0]    trial;

  // trial subtract of the shifted partial remainder
  always_comb begin
    shifted = {rem, quo[ELAPSED_W-1]};
    trial   = shifted - {1'b0, dsr};
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      count   <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        running <= 1'b1;
        count   <= IW'(ITER);
      end else if (running) begin
        count <= count - IW'(1);
        if (count == IW'(1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (req.start) begin
      quo <= req.dividend;
      rem <= '0;
      dsr <= req.divisor;
    end else if (running) begin
      if (!trial[PERIOD_W]) begin
        rem <= trial[PERIOD_W-1:0];
        quo <= {quo[ELAPSED_W-2:0], 1'b1};
      end else begin
        rem <= shifted[PERIOD_W-1:0];
        quo <= {quo[ELAPSED_W-2:0], 1'b0};
      end
    end
  end

  assign rsp.done      = done;
  assign rsp.quotient  = quo;
  assign rsp.remainder = rem;

endmodule

`default_nettype wire

// ===== rtl/sprite_frame_sequencer.sv =====
// ----------------------------------------------------------------------------
// sprite_frame_sequencer: sprite animation frame sequencer
// Keeps frame durations and tiles, advances frames on ticks and works out
// the sprite sheet rectangle of the current tile.
// ----------------------------------------------------------------------------
// Usage: a command transfers at a clock edge with start high and busy low.
// Each command gives one result on play_state, frame_number, tex_x and tex_y,
// marked by done for exactly one cycle; the receiver cannot stall it.
// Play, pause, stop, table writes, ticks while not playing and unused
// opcodes complete without leaving idle, so they can follow each other
// every cycle. Set frame stays busy while the divider computes frame_sel
// mod count. A tick while playing does, as needed: a table read, then a
// compare, per frame step; a period sum over the n frames in use on a wrap;
// a divider reduction for each whole-period or held-frame remainder; and
// the rectangle (divide by tiles per row, then two multiplies on one shared
// multiplier), then the strobe. Each division runs the 33-step shared
// divider, and all table reads go through the single read port.
// Configuration goes through wr_en/wr_index/wr_data while idle. The block
// itself does not enforce that.
// Reset clears time, frame, rectangle and sets playing; the tables hold
// nothing defined until written and need no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module sprite_frame_sequencer
  import sfs_pkg::*;
#(
  parameter int MAX_FRAMES = 64
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // command channel
  input  wire logic        start,
  output logic             busy,
  input  wire logic [2:0]  opcode,
  input  wire logic [31:0] delta_ns,
  input  wire logic [5:0]  frame_sel,
  input  wire logic [31:0] entry_duration,
  input  wire logic [15:0] entry_tile,
  // result channel
  output logic             done,
  output logic      [1:0]  play_state,
  output logic      [5:0]  frame_number,
  output logic      [23:0] tex_x,
  output logic      [23:0] tex_y,
  // configuration
  input  wire logic        wr_en,
  input  wire logic [2:0]  wr_index,
  input  wire logic [12:0] wr_data
);

  localparam int AW = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;

  typedef enum logic [3:0] {
    S_IDLE, S_WAIT, S_STEP, S_SUM_PRE, S_SUM, S_CHK, S_LAST,
    S_RED, S_RECT, S_DIVT, S_MULX, S_MULY, S_ADDY, S_SETF
  } state_t;

  // configuration registers
  logic [11:0] origin_x, origin_y;
  logic [12:0] step_x, step_y, tiles_per_row;
  logic [6:0]  frame_count;
  logic        loop_enable;

  // architectural state
  logic [ELAPSED_W-1:0] elapsed_time;
  logic [CNT_W-1:0]     current_frame;
  mode_t                play_mode;
  logic [23:0]          rect_x, rect_y;

  // sequencer
  state_t              state, ret;
  logic [CNT_W-1:0]    ptr;
  logic [PERIOD_W-1:0] period;
  logic [12:0]         col;
  logic [15:0]         row;
  logic [28:0]         prod;
  div_req_t            div_req;
  div_rsp_t            div_rsp;

  // table ports
  logic          tbl_we;
  logic [AW-1:0] tbl_wr_addr;
  logic [31:0]   rd_dur;
  logic [15:0]   rd_tile;
  logic [AW-1:0] sel_mod [64];

  // derived values
  logic                 accept;
  logic [CNT_W-1:0]     n_eff;
  logic [12:0]          tpr_eff;
  logic [ELAPSED_W-1:0] d_eff;
  logic [ELAPSED_W-1:0] e_sub;
  logic [CNT_W-1:0]     nxt;
  logic [12:0]          mul_a;
  logic [15:0]          mul_b;
  logic [28:0]         mul_res;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      origin_x      <= 12'd0;
      origin_y      <= 12'd0;
      step_x        <= 13'd16;
      step_y        <= 13'd16;
      tiles_per_row <= 13'd1;
      frame_count   <= 7'd1;
      loop_enable   <= 1'b1;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_ORIGIN_X: origin_x      <= wr_data[11:0];
        REG_ORIGIN_Y: origin_y      <= wr_data[11:0];
        REG_STEP_X:   step_x        <= wr_data;
        REG_STEP_Y:   step_y        <= wr_data;
        REG_TPR:      tiles_per_row <= wr_data;
        REG_FCOUNT:   frame_count   <= wr_data[6:0];
        REG_LOOP:     loop_enable   <= wr_data[0];
        default:      ;
      endcase
    end
  end

  // table index of frame_sel, reduced by the table depth
  for (genvar i = 0; i < 64; i++) begin : g_sel_mod
    localparam int unsigned SELM = i % MAX_FRAMES;
    assign sel_mod[i] = AW'(SELM);
  end

  // effective count and tiles per row; zero duration counts as one
  always_comb begin
    if (frame_count == 7'd0) begin
      n_eff = 7'd1;
    end else if (32'(frame_count) > 32'(MAX_FRAMES)) begin
      n_eff = CNT_W'(MAX_FRAMES);
    end else begin
      n_eff = frame_count;
    end
    tpr_eff = (tiles_per_row == 13'd0) ? 13'd1 : tiles_per_row;
    d_eff   = (rd_dur == 32'd0) ? 33'd1 : {1'b0, rd_dur};
    e_sub   = elapsed_time - d_eff;
    nxt     = current_frame + CNT_W'(1);
  end

  // shared multiplier: x pitch by column, then y pitch by row
  always_comb begin
    mul_a   = (state == S_MULY) ? step_y : step_x;
    mul_b   = (state == S_MULY) ? row : {3'b0, col};
    mul_res = 29'(mul_a) * 29'(mul_b);
  end

  assign accept      = start && !busy;
  assign busy        = (state != S_IDLE);
  assign tbl_we      = accept && (opcode == OP_WRITE);
  assign tbl_wr_addr = sel_mod[frame_sel];

  sfs_tables #(
    .DEPTH (MAX_FRAMES),
    .AW    (AW)
  ) u_tables (
    .clk     (clk),
    .we      (tbl_we),
    .wr_addr (tbl_wr_addr),
    .wr_dur  (entry_duration),
    .wr_tile (entry_tile),
    .rd_addr (AW'(ptr)),
    .rd_dur  (rd_dur),
    .rd_tile (rd_tile)
  );

  sfs_divider u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      ret           <= S_IDLE;
      done          <= 1'b0;
      ptr           <= '0;
      div_req.start <= 1'b0;
      elapsed_time  <= '0;
      current_frame <= '0;
      play_mode     <= MODE_PLAYING;
      rect_x        <= 24'd0;
      rect_y        <= 24'd0;
    end else begin
      done          <= 1'b0;
      div_req.start <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            unique case (opcode)
              OP_TICK: begin
                if (play_mode == MODE_PLAYING) begin
                  elapsed_time <= elapsed_time + ELAPSED_W'(delta_ns);
                  ptr          <= current_frame;
                  ret          <= S_STEP;
                  state        <= S_WAIT;
                end else begin
                  done <= 1'b1;
                end
              end
              OP_PLAY: begin
                play_mode <= MODE_PLAYING;
                done      <= 1'b1;
              end
              OP_PAUSE: begin
                play_mode <= MODE_PAUSED;
                done      <= 1'b1;
              end
              OP_STOP: begin
                play_mode     <= MODE_STOPPED;
                current_frame <= '0;
                done          <= 1'b1;
              end
              OP_SETF: begin
                div_req.start    <= 1'b1;
                div_req.dividend <= ELAPSED_W'(frame_sel);
                div_req.divisor  <= PERIOD_W'(n_eff);
                state            <= S_SETF;
              end
              default: begin
                done <= 1'b1;
              end
            endcase
          end
        end

        // table read latency
        S_WAIT: begin
          state <= ret;
        end

        // one frame step: compare against the current duration
        S_STEP: begin
          if (elapsed_time > d_eff) begin
            elapsed_time <= e_sub;
            if (nxt >= n_eff) begin
              if (loop_enable) begin
                current_frame <= '0;
                period        <= '0;
                ptr           <= '0;
                state         <= S_SUM_PRE;
              end else begin
                current_frame <= n_eff - CNT_W'(1);
                play_mode     <= MODE_STOPPED;
                ptr           <= n_eff - CNT_W'(1);
                ret           <= S_LAST;
                state         <= S_WAIT;
              end
            end else begin
              current_frame <= nxt;
              ptr           <= nxt;
              ret           <= S_STEP;
              state         <= S_WAIT;
            end
          end else begin
            state <= S_RECT;
          end
        end

        // period sum, one entry per cycle
        S_SUM_PRE: begin
          ptr   <= CNT_W'(1);
          state <= S_SUM;
        end

        S_SUM: begin
          period <= period + PERIOD_W'(d_eff);
          if (ptr == n_eff) begin
            ptr   <= '0;
            state <= S_CHK;
          end else begin
            ptr <= ptr + CNT_W'(1);
          end
        end

        // remove whole periods at once
        S_CHK: begin
          if (PERIOD_W'(elapsed_time) > period) begin
            div_req.start    <= 1'b1;
            div_req.dividend <= elapsed_time - ELAPSED_W'(1);
            div_req.divisor  <= period;
            ret              <= S_STEP;
            state            <= S_RED;
          end else begin
            state <= S_STEP;
          end
        end

        // held on the last frame: reduce by its duration
        S_LAST: begin
          if (elapsed_time > d_eff) begin
            div_req.start    <= 1'b1;
            div_req.dividend <= elapsed_time - ELAPSED_W'(1);
            div_req.divisor  <= PERIOD_W'(d_eff);
            ret              <= S_RECT;
            state            <= S_RED;
          end else begin
            state <= S_RECT;
          end
        end

        S_RED: begin
          if (div_rsp.done) begin
            elapsed_time <= div_rsp.remainder[ELAPSED_W-1:0] + ELAPSED_W'(1);
            state        <= ret;
          end
        end

        // split tile index into column and row
        S_RECT: begin
          div_req.start    <= 1'b1;
          div_req.dividend <= ELAPSED_W'(rd_tile);
          div_req.divisor  <= PERIOD_W'(tpr_eff);
          state            <= S_DIVT;
        end

        S_DIVT: begin
          if (div_rsp.done) begin
            col   <= div_rsp.remainder[12:0];
            row   <= div_rsp.quotient[15:0];
            state <= S_MULX;
          end
        end

        S_MULX: begin
          prod  <= mul_res;
          state <= S_MULY;
        end

        S_MULY: begin
          rect_x <= 24'(origin_x) + prod[23:0];
          prod   <= mul_res;
          state  <= S_ADDY;
        end

        S_ADDY: begin
          rect_y <= 24'(origin_y) + prod[23:0];
          done   <= 1'b1;
          state  <= S_IDLE;
        end

        S_SETF: begin
          if (div_rsp.done) begin
            current_frame <= div_rsp.remainder[CNT_W-1:0];
            elapsed_time  <= '0;
            done          <= 1'b1;
            state         <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign play_state   = play_mode;
  assign frame_number = current_frame[5:0];
  assign tex_x        = rect_x;
  assign tex_y        = rect_y;

  // a result is only shown once the sequencer is free again
  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result strobe while sequencer busy");

  // divider completion only when the sequencer waits on it
  a_div_wait: assert property (@(posedge clk) disable iff (rst)
    div_rsp.done |-> (state == S_RED || state == S_DIVT || state == S_SETF))
    else $error("divider finished with nobody waiting");

  // a tick while not playing answers in the next cycle
  a_idle_tick: assert property (@(posedge clk) disable iff (rst)
    (accept && opcode == OP_TICK && play_mode != MODE_PLAYING) |=> done)
    else $error("tick while not playing did not complete at once");

endmodule

`default_nettype wire
